// ===== hw/rtl/multilevel_feedback_queue_scheduler_assert.svh =====
// Assertion macros for the multilevel feedback queue scheduler.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MFQS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mfqs check failed");

// Next-cycle implication, checked out of reset.
`define MFQS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mfqs check failed");

`endif

// ===== hw/rtl/mfqs_pkg.sv =====
// Package of the multilevel feedback queue scheduler: sizes, codes, types.
// No dependencies; imported by every module of the block.
`default_nettype none

package mfqs_pkg;

  localparam int unsigned LEVELS    = 5;
  localparam int unsigned MAX_PROCS = 16;
  localparam int unsigned LV_W      = $clog2(LEVELS);
  localparam int unsigned LVC_W     = $clog2(LEVELS + 1);
  localparam int unsigned IDX_W     = $clog2(MAX_PROCS);
  localparam int unsigned CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int unsigned ADDR_W    = LV_W + IDX_W;
  localparam int unsigned MEM_DEPTH = LEVELS << IDX_W;
  localparam int unsigned PID_W     = 4;
  localparam int unsigned NUM_PIDS  = 16;
  localparam int unsigned BURST_W   = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned BASE_W    = 4;
  localparam int unsigned RLEVEL_W  = 3;
  localparam logic [BURST_W-1:0] SLICE_MAX = '1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SLICE_BASE   = 2'd0;
  localparam logic [1:0] CFG_BOOST_PERIOD = 2'd1;
  localparam logic [BASE_W-1:0]  SLICE_BASE_RST   = 4'd4;
  localparam logic [BURST_W-1:0] BOOST_PERIOD_RST = 16'd10;

  typedef enum logic {
    OP_ARRIVE = 1'b0,
    OP_SCHED  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_RAN    = 2'd0,
    STAT_IDLE   = 2'd1,
    STAT_ACCEPT = 2'd2,
    STAT_FULL   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BOOST_CHK,
    ST_BOOST_WR,
    ST_SELECT,
    ST_SLICE,
    ST_RUN,
    ST_DONE
  } back_state_e;

  typedef struct packed {
    logic               command;
    logic [PID_W-1:0]   process_id;
    logic [BURST_W-1:0] burst_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [PID_W-1:0]    run_pid;
    logic [RLEVEL_W-1:0] run_level;
    logic [BURST_W-1:0]  run_length;
    logic                finished;
    logic [TIME_W-1:0]   start_time;
  } out_item_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    op_e                op;
    logic [PID_W-1:0]   pid;
    logic [BURST_W-1:0] burst;
  } cmd_t;

  // Circular index step forward and back.
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(MAX_PROCS - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(MAX_PROCS - 1) : i - 1'b1;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mfqs_front.sv =====
// Front of the scheduler: accepts input transactions, classifies them and
// buffers them in a two-entry command queue. Depends on mfqs_pkg.
`default_nettype none

module mfqs_front import mfqs_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire in_item_t in_item_i,
  output logic          in_full_o,
  output logic          cmd_valid_o,
  output cmd_t          cmd_o,
  input  wire logic     cmd_ready_i
);

  localparam int unsigned DEPTH = 2;

  cmd_t       fifo_q [DEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;
  cmd_t       cls;

  // A zero burst is stored as one tick.
  always_comb begin
    cls.op    = in_item_i.command ? OP_SCHED : OP_ARRIVE;
    cls.pid   = in_item_i.process_id;
    cls.burst = (in_item_i.burst_time == '0) ? BURST_W'(1) : in_item_i.burst_time;
  end

  assign in_full_o   = (count_q == 2'(DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign do_push     = in_valid_i && !in_full_o;
  assign do_pop      = cmd_valid_o && cmd_ready_i;

  // Queue pointers and fill level.
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_q[wr_ptr_q] <= cls;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mfqs_back.sv =====
// Back of the scheduler: level queues, boost walk, slice and run logic.
// Holds the slot memory and per-process remaining time. Depends on mfqs_pkg.
`default_nettype none

module mfqs_back import mfqs_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cmd_valid_i,
  input  wire cmd_t               cmd_i,
  output logic                    cmd_ready_o,
  input  wire logic [BASE_W-1:0]  slice_base_i,
  input  wire logic [BURST_W-1:0] boost_period_i,
  output logic                    res_valid_o,
  output out_item_t               res_o,
  input  wire logic               res_ready_i
);

  back_state_e state_q, state_d;

  logic [IDX_W-1:0]   head_q [LEVELS];
  logic [IDX_W-1:0]   head_d [LEVELS];
  logic [IDX_W-1:0]   tail_q [LEVELS];
  logic [IDX_W-1:0]   tail_d [LEVELS];
  logic [CNT_W-1:0]   cnt_q  [LEVELS];
  logic [CNT_W-1:0]   cnt_d  [LEVELS];
  logic [TIME_W-1:0]  time_q, time_d;
  logic [TIME_W-1:0]  nboost_q, nboost_d;
  logic [LV_W-1:0]    lv_q, lv_d;
  logic [LVC_W-1:0]   blv_q, blv_d;
  logic [LV_W-1:0]    scnt_q, scnt_d;
  logic [BURST_W-1:0] slice_q, slice_d;
  out_item_t          res_q, res_d;

  logic [PID_W-1:0]   mem_q [MEM_DEPTH];
  logic [PID_W-1:0]   rdata_q;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [PID_W-1:0]   mem_wdata;

  logic [BURST_W-1:0] remt_q [NUM_PIDS];
  logic               rem_we;
  logic [PID_W-1:0]   rem_waddr;
  logic [BURST_W-1:0] rem_wdata;

  logic               sel_found;
  logic [LV_W-1:0]    sel_lv;
  logic               boost_due;
  logic               boost_done;
  logic               boost_move;
  logic [LV_W-1:0]    blv;
  logic               slice_done;
  logic [BASE_W-1:0]  base;
  logic [BURST_W+BASE_W-1:0] prod;
  logic [PID_W-1:0]   run_pid;
  logic [BURST_W-1:0] rem, run, new_rem;
  logic [LV_W-1:0]    down, tgt;
  logic [CNT_W-1:0]   down_cnt;
  logic               top_full;

  // Lowest-numbered (highest-priority) non-empty level.
  always_comb begin
    sel_found = 1'b0;
    sel_lv    = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (cnt_q[i] != '0) begin
        sel_found = 1'b1;
        sel_lv    = LV_W'(i);
      end
    end
  end

  // Shared decision flags.
  assign boost_due  = (time_q >= nboost_q);
  assign blv        = blv_q[LV_W-1:0];
  assign boost_done = (blv_q == LVC_W'(LEVELS));
  assign top_full   = (cnt_q[0] == CNT_W'(MAX_PROCS));
  assign boost_move = !boost_done && (cnt_q[blv] != '0) && !top_full;
  assign slice_done = (scnt_q == lv_q);
  assign base       = (slice_base_i == '0) ? BASE_W'(1) : slice_base_i;
  assign prod       = (BURST_W+BASE_W)'(slice_q) * (BURST_W+BASE_W)'(base);

  // Run step values.
  assign run_pid  = rdata_q;
  assign rem      = remt_q[run_pid];
  assign run      = (rem < slice_q) ? rem : slice_q;
  assign new_rem  = rem - run;
  assign down     = (lv_q == LV_W'(LEVELS - 1)) ? lv_q : lv_q + 1'b1;
  assign down_cnt = (down == lv_q) ? cnt_q[lv_q] - 1'b1 : cnt_q[down];
  assign tgt      = (down_cnt == CNT_W'(MAX_PROCS)) ? lv_q : down;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.op == OP_ARRIVE) begin
            state_d = ST_DONE;
          end else if (boost_due) begin
            state_d = ST_BOOST_CHK;
          end else begin
            state_d = ST_SELECT;
          end
        end
      end
      ST_BOOST_CHK: begin
        if (boost_done) begin
          state_d = ST_SELECT;
        end else if (boost_move) begin
          state_d = ST_BOOST_WR;
        end
      end
      ST_BOOST_WR: state_d = ST_BOOST_CHK;
      ST_SELECT:   state_d = sel_found ? ST_SLICE : ST_DONE;
      ST_SLICE:    state_d = slice_done ? ST_RUN : ST_SLICE;
      ST_RUN:      state_d = ST_DONE;
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    cmd_ready_o = (state_q == ST_IDLE);
    res_valid_o = (state_q == ST_DONE);
    res_o       = res_q;
  end

  // Datapath updates per state.
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    cnt_d     = cnt_q;
    time_d    = time_q;
    nboost_d  = nboost_q;
    lv_d      = lv_q;
    blv_d     = blv_q;
    scnt_d    = scnt_q;
    slice_d   = slice_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    rem_we    = 1'b0;
    rem_waddr = '0;
    rem_wdata = '0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          res_d            = '0;
          res_d.start_time = time_q;
          if (cmd_i.op == OP_ARRIVE) begin
            if (top_full) begin
              res_d.status = STAT_FULL;
            end else begin
              res_d.status = STAT_ACCEPT;
              head_d[0]    = idx_dec(head_q[0]);
              cnt_d[0]     = cnt_q[0] + 1'b1;
              mem_we       = 1'b1;
              mem_waddr    = {LV_W'(0), idx_dec(head_q[0])};
              mem_wdata    = cmd_i.pid;
              rem_we       = 1'b1;
              rem_waddr    = cmd_i.pid;
              rem_wdata    = cmd_i.burst;
            end
          end else if (boost_due) begin
            nboost_d = nboost_q + TIME_W'(boost_period_i);
            blv_d    = LVC_W'(1);
          end
        end
      end
      ST_BOOST_CHK: begin
        if (boost_move) begin
          mem_re      = 1'b1;
          mem_raddr   = {blv, head_q[blv]};
          head_d[blv] = idx_inc(head_q[blv]);
          cnt_d[blv]  = cnt_q[blv] - 1'b1;
        end else if (!boost_done) begin
          blv_d = blv_q + 1'b1;
        end
      end
      ST_BOOST_WR: begin
        head_d[0] = idx_dec(head_q[0]);
        cnt_d[0]  = cnt_q[0] + 1'b1;
        mem_we    = 1'b1;
        mem_waddr = {LV_W'(0), idx_dec(head_q[0])};
        mem_wdata = rdata_q;
      end
      ST_SELECT: begin
        if (sel_found) begin
          lv_d      = sel_lv;
          mem_re    = 1'b1;
          mem_raddr = {sel_lv, head_q[sel_lv]};
          slice_d   = BURST_W'(1);
          scnt_d    = '0;
        end else begin
          res_d.status = STAT_IDLE;
          time_d       = time_q + 1'b1;
        end
      end
      ST_SLICE: begin
        if (!slice_done) begin
          slice_d = (prod > (BURST_W+BASE_W)'(SLICE_MAX)) ? SLICE_MAX : prod[BURST_W-1:0];
          scnt_d  = scnt_q + 1'b1;
        end
      end
      ST_RUN: begin
        head_d[lv_q] = idx_inc(head_q[lv_q]);
        cnt_d[lv_q]  = cnt_q[lv_q] - 1'b1;
        rem_we       = 1'b1;
        rem_waddr    = run_pid;
        rem_wdata    = new_rem;
        if (new_rem != '0) begin
          mem_we      = 1'b1;
          mem_waddr   = {tgt, tail_q[tgt]};
          mem_wdata   = run_pid;
          tail_d[tgt] = idx_inc(tail_q[tgt]);
          cnt_d[tgt]  = cnt_d[tgt] + 1'b1;
        end
        time_d           = time_q + ((run == '0) ? TIME_W'(1) : TIME_W'(run));
        res_d.status     = STAT_RAN;
        res_d.run_pid    = run_pid;
        res_d.run_level  = RLEVEL_W'(lv_q);
        res_d.run_length = run;
        res_d.finished   = (new_rem == '0);
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      head_q   <= '{default: '0};
      tail_q   <= '{default: '0};
      cnt_q    <= '{default: '0};
      time_q   <= '0;
      nboost_q <= TIME_W'(BOOST_PERIOD_RST);
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      cnt_q    <= cnt_d;
      time_q   <= time_d;
      nboost_q <= nboost_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    lv_q    <= lv_d;
    blv_q   <= blv_d;
    scnt_q  <= scnt_d;
    slice_q <= slice_d;
    res_q   <= res_d;
  end

  // Slot memory, one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // Remaining time per process id.
  always_ff @(posedge clk_i) begin
    if (rem_we) begin
      remt_q[rem_waddr] <= rem_wdata;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/multilevel_feedback_queue_scheduler.sv =====
// Multilevel feedback queue scheduler. In the back end an arrival transaction
// goes from idle straight to the result state; a schedule step passes the
// select, slice (one multiply per level served) and run states, or goes from
// select to the result state when nothing is queued, and on a boost it first
// checks the levels in turn and moves each entry by a read of the slot memory
// and then a write. A two-entry command queue in front and a result register
// behind let both sides run while the back end is busy.
// Depends on mfqs_pkg, mfqs_front, mfqs_back and the assertion header.
`default_nettype none

`include "multilevel_feedback_queue_scheduler_assert.svh"

module multilevel_feedback_queue_scheduler import mfqs_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  input  wire in_item_t           in_data_i,
  output logic                    full,
  output logic                    empty,
  input  wire logic               pop,
  output out_item_t               out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [BURST_W-1:0] cfg_data_i
);

  logic               cmd_valid, cmd_ready;
  cmd_t               cmd;
  logic               res_valid, res_ready;
  out_item_t          res;
  logic [BASE_W-1:0]  slice_base_q;
  logic [BURST_W-1:0] boost_period_q;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q;

  mfqs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push),
    .in_item_i   (in_data_i),
    .in_full_o   (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  mfqs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_ready_o    (cmd_ready),
    .slice_base_i   (slice_base_q),
    .boost_period_i (boost_period_q),
    .res_valid_o    (res_valid),
    .res_o          (res),
    .res_ready_i    (res_ready)
  );

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_base_q   <= SLICE_BASE_RST;
      boost_period_q <= BOOST_PERIOD_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SLICE_BASE:   slice_base_q   <= cfg_data_i[BASE_W-1:0];
        CFG_BOOST_PERIOD: boost_period_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Result register between the back end and the output side.
  assign res_ready  = !out_valid_q || pop;
  assign empty      = !out_valid_q;
  assign out_data_o = out_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (pop && out_valid_q) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  // A transaction from the back end is visible on the next cycle.
  `MFQS_ASSERT_NEXT(a_res_lands, res_valid && res_ready, !empty)
  // An idle tick reports no process.
  `MFQS_ASSERT_NOW(a_idle_clean, !empty && out_data_o.status == STAT_IDLE, out_data_o.run_pid == '0 && out_data_o.run_length == '0)
  // An unfinished run always made progress.
  `MFQS_ASSERT_NOW(a_run_progress, !empty && out_data_o.status == STAT_RAN && !out_data_o.finished, out_data_o.run_length != '0)

endmodule

`default_nettype wire

// ===== tb/mfqs_checker.sv =====
// Checker of the multilevel feedback queue scheduler: it predicts every result
// from the observed command, result and configuration transactions.
// Depends on mfqs_pkg only.
`timescale 1ns / 1ps

module mfqs_checker import mfqs_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  input  wire logic               full,
  input  wire in_item_t           in_data_i,
  input  wire logic               empty,
  input  wire logic               pop,
  input  wire out_item_t          out_data_i,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_ready_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [BURST_W-1:0] cfg_data_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  // Shadow state of the scheduler.
  logic [PID_W-1:0]   slots [LEVELS][MAX_PROCS];
  logic [BURST_W-1:0] remaining [NUM_PIDS];
  logic [IDX_W-1:0]   head [LEVELS];
  logic [IDX_W-1:0]   tail [LEVELS];
  int unsigned        count [LEVELS];
  logic [TIME_W-1:0]  now_ticks;
  logic [TIME_W-1:0]  boost_at;
  logic [BASE_W-1:0]  slice_base;
  logic [BURST_W-1:0] boost_period;

  out_item_t expected_results [$];
  int fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_results.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fails++;
  endtask

  function automatic bit level_push_front(input int lv, input logic [PID_W-1:0] pid);
    if (count[lv] >= MAX_PROCS) return 0;
    head[lv] = head[lv] - 1'b1;
    slots[lv][head[lv]] = pid;
    count[lv]++;
    return 1;
  endfunction

  function automatic bit level_push_back(input int lv, input logic [PID_W-1:0] pid);
    if (count[lv] >= MAX_PROCS) return 0;
    slots[lv][tail[lv]] = pid;
    tail[lv] = tail[lv] + 1'b1;
    count[lv]++;
    return 1;
  endfunction

  function automatic logic [PID_W-1:0] level_pop(input int lv);
    logic [PID_W-1:0] pid;
    pid = slots[lv][head[lv]];
    head[lv] = head[lv] + 1'b1;
    count[lv]--;
    return pid;
  endfunction

  // Advances the shadow state by one command and returns its result.
  function automatic out_item_t schedule_command(input in_item_t cmd);
    out_item_t r;
    logic [BURST_W-1:0] burst;
    logic [PID_W-1:0] pid;
    int unsigned lv, base, slice, rem, run, down;
    bit ok;
    r = '0;
    r.start_time = now_ticks;
    if (cmd.command == OP_ARRIVE) begin
      burst = (cmd.burst_time == '0) ? BURST_W'(1) : cmd.burst_time;
      if (level_push_front(0, cmd.process_id)) begin
        remaining[cmd.process_id] = burst;
        r.status = STAT_ACCEPT;
      end else begin
        r.status = STAT_FULL;
      end
      return r;
    end
    // Priority boost: lower levels move to the top, each head first.
    if (now_ticks >= boost_at) begin
      for (int l = 1; l < LEVELS; l++)
        while (count[l] > 0 && count[0] < MAX_PROCS)
          ok = level_push_front(0, level_pop(l));
      boost_at = boost_at + TIME_W'(boost_period);
    end
    lv = LEVELS;
    for (int l = LEVELS - 1; l >= 0; l--)
      if (count[l] > 0) lv = l;
    if (lv == LEVELS) begin
      now_ticks = now_ticks + 1;
      r.status = STAT_IDLE;
      return r;
    end
    pid = level_pop(lv);
    rem = remaining[pid];
    base = (slice_base == '0) ? 1 : slice_base;
    slice = 1;
    for (int l = 0; l < lv; l++) begin
      slice = slice * base;
      if (slice > 65535) slice = 65535;
    end
    run = (rem < slice) ? rem : slice;
    rem = rem - run;
    remaining[pid] = BURST_W'(rem);
    // Demotion; a full lower level keeps the process where it was.
    if (rem != 0) begin
      down = (lv + 1 < LEVELS) ? lv + 1 : lv;
      if (!level_push_back(down, pid)) ok = level_push_back(lv, pid);
    end
    now_ticks = now_ticks + ((run == 0) ? 1 : run);
    r.status     = STAT_RAN;
    r.run_pid    = pid;
    r.run_level  = RLEVEL_W'(lv);
    r.run_length = BURST_W'(run);
    r.finished   = (rem == 0);
    return r;
  endfunction

  // Watch all three channels and compare results in order.
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      for (int l = 0; l < LEVELS; l++) begin
        head[l] = '0;
        tail[l] = '0;
        count[l] = 0;
      end
      now_ticks = '0;
      slice_base = SLICE_BASE_RST;
      boost_period = BOOST_PERIOD_RST;
      boost_at = TIME_W'(BOOST_PERIOD_RST);
      expected_results.delete();
      fails = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_SLICE_BASE) slice_base = cfg_data_i[BASE_W-1:0];
        else if (cfg_index_i == CFG_BOOST_PERIOD) boost_period = cfg_data_i;
      end
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          report("unexpected result status", out_data_i.status, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.status !== want.status)
            report("status", out_data_i.status, want.status);
          if (out_data_i.run_pid !== want.run_pid)
            report("run_pid", out_data_i.run_pid, want.run_pid);
          if (out_data_i.run_level !== want.run_level)
            report("run_level", out_data_i.run_level, want.run_level);
          if (out_data_i.run_length !== want.run_length)
            report("run_length", out_data_i.run_length, want.run_length);
          if (out_data_i.finished !== want.finished)
            report("finished", out_data_i.finished, want.finished);
          if (out_data_i.start_time !== want.start_time)
            report("start_time", out_data_i.start_time, want.start_time);
        end
      end
      if (push && !full) expected_results.push_back(schedule_command(in_data_i));
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top of the multilevel feedback queue scheduler: clock, reset,
// stimulus and verdict. Depends on mfqs_pkg, mfqs_checker and the block.
`timescale 1ns / 1ps

module tb_top;
  import mfqs_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 200;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 230;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               pop = 1'b0;
  logic               full, empty, cfg_ready;
  in_item_t           in_data = '0;
  out_item_t          out_data;
  logic               cfg_valid = 1'b0;
  logic [1:0]         cfg_index = CFG_SLICE_BASE;
  logic [BURST_W-1:0] cfg_data = '0;
  int                 fail_count, pending;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 cycles = 0;
  int                 slice_set [PHASES] = '{4, 1, 8, 0, 15, 2, 3, 8};
  int                 period_set [PHASES] = '{10, 1, 65535, 0, 3, 25, 7, 1};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  multilevel_feedback_queue_scheduler i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push        (push),
    .in_data_i   (in_data),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  mfqs_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .push         (push),
    .full         (full),
    .in_data_i    (in_data),
    .empty        (empty),
    .pop          (pop),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Result side: random stalls at the rate of the current phase.
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL multilevel_feedback_queue_scheduler");
      $finish;
    end
  end

  // Drives one command transaction and returns at the edge that accepts it.
  task automatic send_command(input op_e op, input logic [PID_W-1:0] pid,
                              input logic [BURST_W-1:0] burst);
    bit taken;
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    push <= 1'b1;
    in_data <= '{command: op, process_id: pid, burst_time: burst};
    do begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Drives one register write; valid drops for a cycle before the next one.
  task automatic write_register(input logic [1:0] idx, input logic [BURST_W-1:0] data);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [BURST_W-1:0] random_burst();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return BURST_W'($urandom_range(65535));
    if (r < 13) return '1;
    return BURST_W'($urandom_range(30, 1));
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset settings: burst extremes, a zero burst,
    // a full top level, idle ticks and boosts.
    send_command(OP_SCHED, 4'd0, '0);
    send_command(OP_ARRIVE, 4'd15, '1);
    send_command(OP_ARRIVE, 4'd0, '0);
    for (int i = 0; i < 17; i++) send_command(OP_ARRIVE, PID_W'(i), BURST_W'(i % 3 + 1));
    for (int i = 0; i < 5; i++) send_command(OP_SCHED, '1, '1);
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      write_register(CFG_SLICE_BASE, {BURST_W'($urandom_range(4095)), BASE_W'(slice_set[p])});
      write_register(CFG_BOOST_PERIOD, BURST_W'(period_set[p]));
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // In phase 2, after 100 items, hold the sender until every pending result has come back.
        if (p == 2 && n == 100) begin
          push <= 1'b0;
          do @(negedge clk); while (pending != 0);
          @(posedge clk);
        end
        if ($urandom_range(99) < 45)
          send_command(OP_ARRIVE, PID_W'($urandom_range(15)), random_burst());
        else
          send_command(OP_SCHED, PID_W'($urandom_range(15)), BURST_W'($urandom_range(65535)));
      end
      drain_results();
    end

    if (fail_count == 0) begin
      $display("PASS multilevel_feedback_queue_scheduler");
    end else begin
      $display("FAIL multilevel_feedback_queue_scheduler");
    end
    $finish;
  end

endmodule
